/* sv/ikc_pkg.sv */
// Shared types and constants of the image kernel convolution core.
package ikc_pkg;

  localparam int PIX_W       = 8;
  localparam int COEF_W      = 12;
  localparam int KMAX        = 5;
  localparam int ROW_W       = KMAX * COEF_W;
  localparam int CFG_IDX_W   = 4;
  localparam int DIM_W       = 11;
  localparam int PROD_W      = PIX_W + 1 + COEF_W;
  localparam int ROWSUM_W    = PROD_W + 3;
  localparam int SUM_W       = ROWSUM_W + 2;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = 3;
  localparam int FIFO_CNT_W  = 4;
  localparam int MEM_ROWS    = KMAX - 1;
  localparam int MEM_W       = MEM_ROWS * PIX_W;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KSIZE  = 4'd0,
    REG_WIDTH  = 4'd1,
    REG_HEIGHT = 4'd2,
    REG_COEF_A = 4'd3,
    REG_COEF_B = 4'd4,
    REG_COEF_C = 4'd5,
    REG_COEF_D = 4'd6,
    REG_COEF_E = 4'd7
  } reg_idx_t;

  // One column of the window: element m holds row (r - 4 + m).
  typedef logic [KMAX-1:0][PIX_W-1:0] vec_t;

  typedef struct packed {
    logic                  last;
    logic                  k5;
    logic [KMAX-1:0][2:0]  dep;
  } ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered_value;
    logic             clipped;
    logic             frame_last;
  } res_t;

endpackage

/* sv/ikc_in_if.sv */
// Input pixel channel.
interface ikc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] pixel_value;
  modport source (output valid, output opcode, output pixel_value, input ready);
  modport sink (input valid, input opcode, input pixel_value, output ready);
endinterface

/* sv/ikc_out_if.sv */
// Result channel.
interface ikc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_value;
  logic       clipped;
  logic       frame_last;
  modport source (output valid, output filtered_value, output clipped, output frame_last,
                  input ready);
  modport sink (input valid, input filtered_value, input clipped, input frame_last,
                output ready);
endinterface

/* sv/ikc_cfg_if.sv */
// Configuration write channel.
interface ikc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [59:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/ikc_line_mem.sv */
// Column store holding the four previous rows of every column.
module ikc_line_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [ikc_pkg::MEM_W-1:0]        rdata,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [ikc_pkg::MEM_W-1:0]        wdata
);

  logic [ikc_pkg::MEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/ikc_mac.sv */
// Window tap selection, coefficient products, adder tree and saturation.
module ikc_mac #(
  parameter int COEF_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_v,
  input  ikc_pkg::ctl_t                     ctl,
  input  ikc_pkg::vec_t                     hist [ikc_pkg::KMAX],
  input  logic [ikc_pkg::ROW_W-1:0]         coef [ikc_pkg::KMAX],
  output logic                              res_v,
  output ikc_pkg::res_t                     res
);

  localparam int K = ikc_pkg::KMAX;

  logic signed [ikc_pkg::PROD_W-1:0]   prod_nxt [K][K];
  logic signed [ikc_pkg::PROD_W-1:0]   prod_r   [K][K];
  logic signed [ikc_pkg::ROWSUM_W-1:0] rows_nxt [K];
  logic signed [ikc_pkg::ROWSUM_W-1:0] rows_r   [K];
  logic signed [ikc_pkg::SUM_W-1:0]    tot_nxt;
  logic signed [ikc_pkg::SUM_W-1:0]    tot_r;
  logic signed [ikc_pkg::SUM_W-1:0]    adj;
  logic signed [ikc_pkg::SUM_W-1:0]    q;
  logic [2:0]                          v_r;
  logic [2:0]                          last_r;

  always_comb begin
    logic       used;
    logic [2:0] m;
    logic [2:0] kr;
    logic [2:0] kc;
    logic signed [ikc_pkg::PIX_W:0]    pxs;
    logic signed [ikc_pkg::COEF_W-1:0] cf;
    for (int a = 0; a < K; a++) begin
      for (int b = 0; b < K; b++) begin
        used = ctl.k5 || (a >= 1 && a <= 3 && b >= 1 && b <= 3);
        m    = ctl.k5 ? 3'(a) : 3'(a + 1);
        kr   = ctl.k5 ? 3'(4 - a) : 3'(3 - a);
        kc   = ctl.k5 ? 3'(4 - b) : 3'(3 - b);
        if (used) begin
          pxs = signed'({1'b0, hist[ctl.dep[b]][m]});
          cf  = signed'(coef[kr][kc * ikc_pkg::COEF_W +: ikc_pkg::COEF_W]);
          prod_nxt[a][b] = ikc_pkg::PROD_W'(pxs * cf);
        end else begin
          pxs = '0;
          cf  = '0;
          prod_nxt[a][b] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < K; a++) begin
      rows_nxt[a] = '0;
      for (int b = 0; b < K; b++) begin
        rows_nxt[a] = rows_nxt[a] + ikc_pkg::ROWSUM_W'(prod_r[a][b]);
      end
    end
    tot_nxt = '0;
    for (int a = 0; a < K; a++) begin
      tot_nxt = tot_nxt + ikc_pkg::SUM_W'(rows_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rows_r <= rows_nxt;
    tot_r  <= tot_nxt;
    if (!rst_n) begin
      v_r    <= '0;
      last_r <= '0;
    end else begin
      v_r    <= {v_r[1:0], in_v};
      last_r <= {last_r[1:0], ctl.last};
    end
  end

  // Division by the coefficient scale, rounded toward zero, then saturation to 0..255.
  always_comb begin
    adj = tot_r;
    if (tot_r < 0) begin
      adj = tot_r + ikc_pkg::SUM_W'((1 << COEF_FRAC_BITS) - 1);
    end
    q = adj >>> COEF_FRAC_BITS;
    res.frame_last = last_r[2];
    if (q < 0) begin
      res.filtered_value = '0;
      res.clipped        = 1'b1;
    end else if (q > 255) begin
      res.filtered_value = '1;
      res.clipped        = 1'b1;
    end else begin
      res.filtered_value = q[ikc_pkg::PIX_W-1:0];
      res.clipped        = 1'b0;
    end
  end

  assign res_v = v_r[2];

endmodule

/* sv/ikc_out_fifo.sv */
// Result queue in front of the output channel.
module ikc_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ikc_pkg::res_t  wr,
  input  logic           pop,
  output logic           not_empty,
  output ikc_pkg::res_t  rd
);

  ikc_pkg::res_t                   buf_r [ikc_pkg::FIFO_DEPTH];
  logic [ikc_pkg::FIFO_AW-1:0]     wp_r;
  logic [ikc_pkg::FIFO_AW-1:0]     rp_r;
  logic [ikc_pkg::FIFO_CNT_W-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= wr;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + ikc_pkg::FIFO_CNT_W'(push) - ikc_pkg::FIFO_CNT_W'(pop);
    end
  end

  assign not_empty = (cnt_r != '0);
  assign rd        = buf_r[rp_r];

endmodule

/* sv/image_kernel_convolution_core.sv */
// Image kernel convolution core: top level with raster control, window and configuration.
// Accepts one word per clock while the queue has room and returns one result per clock
// while the sink is ready, once the window lag (one or two rows plus one or two pixels)
// has filled; results queue in an eight-word buffer, so input flows on while the sink
// stalls until it fills. Each accepted column reads and rewrites one entry of the column
// store, whose single read port sets the rate of one word per cycle; results pass the
// store read, window, product, row-sum and total registers. After the last pixel of a
// frame of one or two rows (fewer pixels than the lag), the core steps through the missing
// window positions, taking no word. Drain words release the pending results at frame end.
module image_kernel_convolution_core #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 1024,
  parameter int COEF_FRAC_BITS = 8
) (
  input logic       clk,
  input logic       rst_n,
  ikc_in_if.sink    in_chan,
  ikc_out_if.source out_chan,
  ikc_cfg_if.sink   cfg_chan
);

  localparam int K  = ikc_pkg::KMAX;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int PW = $clog2(MAX_WIDTH * (MAX_HEIGHT + 3) + 1);

  // Configuration registers.
  logic                       ksize_r;
  logic [ikc_pkg::DIM_W-1:0]  width_r;
  logic [ikc_pkg::DIM_W-1:0]  height_r;
  logic [ikc_pkg::ROW_W-1:0]  coef_r [K];

  // Frame control.
  logic          active_r;
  logic          done_r;
  logic [CW-1:0] lat_w_r;
  logic [HW-1:0] lat_h_r;
  logic          lat_k5_r;
  logic [PW-1:0] lag_r;
  logic [AW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [PW-1:0] p_r;
  logic [AW-1:0] ocol_r;
  logic [HW-1:0] orow_r;
  logic [ikc_pkg::FIFO_CNT_W-1:0] res_cnt_r;

  logic          in_fire;
  logic          out_fire;
  logic          adv;
  logic          catchup;
  logic          step;
  logic          emit;
  logic          last;
  logic [CW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          eff_k5;
  logic [PW-1:0] eff_lag;
  logic [2:0]    rc;
  ikc_pkg::ctl_t ctl_nxt;

  // Column pipeline.
  logic                       s1_v_r;
  logic [ikc_pkg::PIX_W-1:0]  s1_pix_r;
  logic                       s1_virt_r;
  logic [2:0]                 s1_rc_r;
  logic                       s1_fwd_r;
  logic [AW-1:0]              s1_addr_r;
  logic                       s1_emit_r;
  ikc_pkg::ctl_t              s1_ctl_r;
  logic                       s2_v_r;
  ikc_pkg::ctl_t              s2_ctl_r;
  logic [ikc_pkg::MEM_W-1:0]  rdata;
  logic [ikc_pkg::MEM_W-1:0]  wdata;
  logic [ikc_pkg::MEM_W-1:0]  wlast_r;
  logic [ikc_pkg::MEM_W-1:0]  raw_word;
  ikc_pkg::vec_t              raw;
  ikc_pkg::vec_t              vcol;
  ikc_pkg::vec_t              hist_r [K];

  logic          res_v;
  ikc_pkg::res_t res;
  ikc_pkg::res_t fifo_rd;
  logic          fifo_ne;

  function automatic logic [CW-1:0] clamp_w(input logic [ikc_pkg::DIM_W-1:0] v);
    if (v == '0) begin
      return CW'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      return CW'(MAX_WIDTH);
    end
    return CW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [ikc_pkg::DIM_W-1:0] v);
    if (v == '0) begin
      return HW'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      return HW'(MAX_HEIGHT);
    end
    return HW'(v);
  endfunction

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksize_r   <= 1'b0;
      width_r   <= ikc_pkg::DIM_W'(1024);
      height_r  <= ikc_pkg::DIM_W'(1024);
      coef_r[0] <= '0;
      coef_r[1] <= '0;
      coef_r[2] <= ikc_pkg::ROW_W'(256);
      coef_r[3] <= '0;
      coef_r[4] <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        ikc_pkg::REG_KSIZE:  ksize_r   <= cfg_chan.data[0];
        ikc_pkg::REG_WIDTH:  width_r   <= cfg_chan.data[ikc_pkg::DIM_W-1:0];
        ikc_pkg::REG_HEIGHT: height_r  <= cfg_chan.data[ikc_pkg::DIM_W-1:0];
        ikc_pkg::REG_COEF_A: coef_r[0] <= cfg_chan.data;
        ikc_pkg::REG_COEF_B: coef_r[1] <= cfg_chan.data;
        ikc_pkg::REG_COEF_C: coef_r[2] <= cfg_chan.data;
        ikc_pkg::REG_COEF_D: coef_r[3] <= cfg_chan.data;
        ikc_pkg::REG_COEF_E: coef_r[4] <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w   = active_r ? lat_w_r : clamp_w(width_r);
    eff_h   = active_r ? lat_h_r : clamp_h(height_r);
    eff_k5  = active_r ? lat_k5_r : ksize_r;
    eff_lag = active_r ? lag_r :
              (eff_k5 ? (PW'(eff_w) << 1) + PW'(2) : PW'(eff_w) + PW'(1));
    in_fire  = in_chan.valid && in_chan.ready;
    out_fire = out_chan.valid && out_chan.ready;
    adv      = (in_chan.opcode == ikc_pkg::OP_PIXEL) || done_r;
    catchup  = done_r && (p_r < lag_r);
    step     = (in_fire && adv) || catchup;
    emit     = step && (p_r >= eff_lag);
    last     = (orow_r == eff_h - 1'b1) && (CW'(ocol_r) == eff_w - 1'b1);
    rc       = (row_r >= RW'(4)) ? 3'd4 : row_r[2:0];
  end

  assign in_chan.ready = !catchup && (res_cnt_r < ikc_pkg::FIFO_CNT_W'(ikc_pkg::FIFO_DEPTH));

  // Window column chosen for each kernel column, with the left and right edges replicated.
  always_comb begin
    logic signed [CW+2:0] off;
    logic signed [CW+2:0] co;
    logic signed [CW+2:0] cj;
    logic signed [CW+2:0] cl;
    off = eff_k5 ? (CW+3)'(2) : (CW+3)'(1);
    co  = signed'((CW+3)'(ocol_r));
    ctl_nxt.last = last;
    ctl_nxt.k5   = eff_k5;
    for (int b = 0; b < K; b++) begin
      cj = co + (CW+3)'(b - 2);
      if (cj < 0) begin
        cl = '0;
      end else if (cj > signed'((CW+3)'(eff_w) - (CW+3)'(1))) begin
        cl = signed'((CW+3)'(eff_w) - (CW+3)'(1));
      end else begin
        cl = cj;
      end
      ctl_nxt.dep[b] = 3'(off + co - cl);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      done_r    <= 1'b0;
      lat_w_r   <= CW'(1);
      lat_h_r   <= HW'(1);
      lat_k5_r  <= 1'b0;
      lag_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
      p_r       <= '0;
      ocol_r    <= '0;
      orow_r    <= '0;
      res_cnt_r <= '0;
    end else begin
      res_cnt_r <= res_cnt_r + ikc_pkg::FIFO_CNT_W'(emit) - ikc_pkg::FIFO_CNT_W'(out_fire);
      if (step) begin
        if (!active_r) begin
          active_r <= 1'b1;
          lat_w_r  <= eff_w;
          lat_h_r  <= eff_h;
          lat_k5_r <= eff_k5;
          lag_r    <= eff_lag;
        end
        p_r <= p_r + 1'b1;
        if (CW'(col_r) + CW'(1) == eff_w) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
          if (!done_r && (row_r + RW'(1) == RW'(eff_h))) begin
            done_r <= 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
        if (emit) begin
          if (last) begin
            active_r <= 1'b0;
            done_r   <= 1'b0;
            col_r    <= '0;
            row_r    <= '0;
            p_r      <= '0;
            ocol_r   <= '0;
            orow_r   <= '0;
          end else if (CW'(ocol_r) + CW'(1) == eff_w) begin
            ocol_r <= '0;
            orow_r <= orow_r + 1'b1;
          end else begin
            ocol_r <= ocol_r + 1'b1;
          end
        end
      end
    end
  end

  ikc_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_mem (
    .clk   (clk),
    .re    (step),
    .raddr (col_r),
    .rdata (rdata),
    .we    (s1_v_r),
    .waddr (s1_addr_r),
    .wdata (wdata)
  );

  always_ff @(posedge clk) begin
    s1_pix_r  <= in_chan.pixel_value;
    s1_virt_r <= done_r;
    s1_rc_r   <= rc;
    s1_fwd_r  <= s1_v_r && (s1_addr_r == col_r);
    s1_addr_r <= col_r;
    s1_ctl_r  <= ctl_nxt;
    s2_ctl_r  <= s1_ctl_r;
    if (s1_v_r) begin
      wlast_r <= wdata;
      hist_r[0] <= vcol;
      for (int i = 1; i < K; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_emit_r <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      s1_v_r    <= step;
      s1_emit_r <= emit;
      s2_v_r    <= s1_v_r && s1_emit_r;
    end
  end

  // New column: rows above the frame repeat the top row; rows below it repeat the bottom row.
  always_comb begin
    raw_word = s1_fwd_r ? wlast_r : rdata;
    for (int k = 0; k < ikc_pkg::MEM_ROWS; k++) begin
      raw[k] = raw_word[k * ikc_pkg::PIX_W +: ikc_pkg::PIX_W];
    end
    raw[K-1] = s1_virt_r ? raw[K-2] : s1_pix_r;
    for (int m = 0; m < K; m++) begin
      if (3'(m) < 3'd4 - s1_rc_r) begin
        vcol[m] = raw[3'd4 - s1_rc_r];
      end else begin
        vcol[m] = raw[m];
      end
    end
    for (int k = 0; k < ikc_pkg::MEM_ROWS; k++) begin
      wdata[k * ikc_pkg::PIX_W +: ikc_pkg::PIX_W] = vcol[k+1];
    end
  end

  ikc_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .in_v  (s2_v_r),
    .ctl   (s2_ctl_r),
    .hist  (hist_r),
    .coef  (coef_r),
    .res_v (res_v),
    .res   (res)
  );

  ikc_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_v),
    .wr        (res),
    .pop       (out_fire),
    .not_empty (fifo_ne),
    .rd        (fifo_rd)
  );

  assign out_chan.valid          = fifo_ne;
  assign out_chan.filtered_value = fifo_rd.filtered_value;
  assign out_chan.clipped        = fifo_rd.clipped;
  assign out_chan.frame_last     = fifo_rd.frame_last;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= ikc_pkg::FIFO_CNT_W'(ikc_pkg::FIFO_DEPTH))
    else $error("result credit count exceeds the queue depth");

  a_catchup_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    catchup |-> !in_chan.ready)
    else $error("input taken while the window catches up");

  a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (res_cnt_r != '0))
    else $error("result word offered without an outstanding credit");

  a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !active_r) |-> (eff_lag == '0))
    else $error("result released outside an active frame");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the image kernel convolution core.
`timescale 1ns / 100ps

module tb;
  import ikc_pkg::*;

  localparam int STORE_DEPTH = 4 * 1024 + 8;
  localparam int MAX_DIM = 1024;
  localparam int SETTLE_CYCLES = 2 * MAX_DIM + 64;

  typedef struct {
    opcode_t    op;
    logic [7:0] px;
  } word_t;

  logic clk;
  logic rst_n;

  ikc_in_if  in_if ();
  ikc_out_if out_if ();
  ikc_cfg_if cfg_if ();

  image_kernel_convolution_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Register copies, updated when the write is accepted.
  logic              reg_k5;
  logic [DIM_W-1:0]  reg_w;
  logic [DIM_W-1:0]  reg_h;
  logic [ROW_W-1:0]  reg_coef [KMAX];

  // Predictor state.
  logic [7:0] pix_store [STORE_DEPTH];
  int  in_row, in_col, out_row, out_col;
  bit  frame_open, input_complete;
  int  frame_w, frame_h, frame_off;

  word_t word_queue [$];
  res_t  expected_results [$];
  int    errors;
  int    random_words;

  bit hold_go;
  bit hold_done;
  int hold_cnt;
  int stall_mode;
  int stall_phase;
  int burst_left;
  int gap_left;

  always #4 clk = ~clk;

  function automatic int clamp_dim(int v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int clamp_pos(int v, int n);
    if (v < 0) return 0;
    if (v >= n) return n - 1;
    return v;
  endfunction

  function automatic res_t convolve_next();
    res_t r;
    int acc, q, rr, cc, kr, kc;
    logic signed [COEF_W-1:0] k;
    acc = 0;
    for (int i = -frame_off; i <= frame_off; i++) begin
      for (int j = -frame_off; j <= frame_off; j++) begin
        rr = clamp_pos(out_row + i, frame_h);
        cc = clamp_pos(out_col + j, frame_w);
        kr = frame_off - i;
        kc = frame_off - j;
        k = reg_coef[kr][kc*COEF_W +: COEF_W];
        acc += int'(pix_store[(rr * frame_w + cc) % STORE_DEPTH]) * int'(k);
      end
    end
    q = acc / (1 << 8);
    r.clipped = (q < 0 || q > 255);
    r.filtered_value = (q < 0) ? 8'd0 : (q > 255) ? 8'd255 : q[7:0];
    r.frame_last = (out_row == frame_h - 1 && out_col == frame_w - 1);
    if (r.frame_last) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      input_complete = 0;
      frame_open = 0;
    end else begin
      out_col++;
      if (out_col >= frame_w) begin
        out_col = 0;
        out_row++;
      end
    end
    return r;
  endfunction

  function automatic void predict_word(opcode_t op, logic [7:0] px);
    int p;
    if (op == OP_PIXEL && !input_complete) begin
      if (!frame_open) begin
        frame_w = clamp_dim(reg_w);
        frame_h = clamp_dim(reg_h);
        frame_off = reg_k5 ? 2 : 1;
        frame_open = 1;
      end
      p = in_row * frame_w + in_col;
      pix_store[p % STORE_DEPTH] = px;
      in_col++;
      if (in_col >= frame_w) begin
        in_col = 0;
        in_row++;
        if (in_row >= frame_h) input_complete = 1;
      end
      if (p >= frame_off * frame_w + frame_off) expected_results.push_back(convolve_next());
    end else if (input_complete) begin
      expected_results.push_back(convolve_next());
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.opcode <= OP_PIXEL;
      in_if.pixel_value <= 8'd0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_if.valid && in_if.ready) predict_word(opcode_t'(in_if.opcode), in_if.pixel_value);
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (word_queue.size() > 0) begin
          w = word_queue.pop_front();
          in_if.valid <= 1'b1;
          in_if.opcode <= w.op;
          in_if.pixel_value <= w.px;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // The long hold-off of the receiver.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_cnt <= 400;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Receiver: the stall pattern changes each time the stall phase counter wraps.
  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_mode <= 0;
      stall_phase <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.filtered_value = out_if.filtered_value;
        got.clipped = out_if.clipped;
        got.frame_last = out_if.frame_last;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word value=%0d clipped=%0b last=%0b", $time,
                   got.filtered_value, got.clipped, got.frame_last);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.filtered_value !== want.filtered_value) begin
            $display("%0t: filtered_value expected %0d actual %0d", $time,
                     want.filtered_value, got.filtered_value);
            errors++;
          end
          if (got.clipped !== want.clipped) begin
            $display("%0t: clipped expected %0b actual %0b", $time, want.clipped, got.clipped);
            errors++;
          end
          if (got.frame_last !== want.frame_last) begin
            $display("%0t: frame_last expected %0b actual %0b", $time,
                     want.frame_last, got.frame_last);
            errors++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 64;
      if (stall_phase == 63) stall_mode <= $urandom_range(0, 2);
      out_if.ready <= (hold_cnt == 0) &&
                      (stall_mode == 0 || $urandom_range(0, stall_mode + 1) != 0);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [ROW_W-1:0] v);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_KSIZE:  reg_k5 = v[0];
      REG_WIDTH:  reg_w = v[DIM_W-1:0];
      REG_HEIGHT: reg_h = v[DIM_W-1:0];
      default:    reg_coef[idx - REG_COEF_A] = v;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (word_queue.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ROW_W-1:0] random_coef_row();
    logic [ROW_W-1:0] row;
    logic [COEF_W-1:0] c;
    for (int k = 0; k < KMAX; k++) begin
      case ($urandom_range(0, 3))
        0: c = $urandom_range(0, 4095);
        1: c = 0;
        default: c = $urandom_range(0, 96) - 48;
      endcase
      row[k*COEF_W +: COEF_W] = c;
    end
    return row;
  endfunction

  function automatic void push_word(opcode_t op, logic [7:0] px);
    word_t w;
    w.op = op;
    w.px = px;
    word_queue.push_back(w);
  endfunction

  // Queues one frame: its pixels, then drain words until the last result; a noisy frame also mixes in stray words.
  function automatic int queue_frame(int pix_sel, bit noisy);
    int w, h, off, n, drains, cnt;
    w = clamp_dim(reg_w);
    h = clamp_dim(reg_h);
    off = reg_k5 ? 2 : 1;
    n = w * h;
    drains = (n < off * w + off) ? n : off * w + off;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        push_word(OP_DRAIN, $urandom_range(0, 255));
        cnt++;
      end
      case (pix_sel)
        0: push_word(OP_PIXEL, $urandom_range(0, 255));
        1: push_word(OP_PIXEL, (i % 2) ? 8'd255 : 8'd0);
        default: push_word(OP_PIXEL, ($urandom_range(0, 1) ? 8'd255 : 8'd0));
      endcase
      cnt++;
    end
    for (int i = 0; i < drains; i++) begin
      push_word((noisy && $urandom_range(0, 7) == 0) ? OP_PIXEL : OP_DRAIN,
                $urandom_range(0, 255));
      cnt++;
    end
    if (noisy && $urandom_range(0, 3) == 0) begin
      push_word(OP_DRAIN, $urandom_range(0, 255));
      cnt++;
    end
    return cnt;
  endfunction

  initial begin
    int frames;
    clk = 1'b0;
    rst_n = 1'b0;
    errors = 0;
    random_words = 0;
    hold_go = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_KSIZE;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_PIXEL;
    in_if.pixel_value = 8'd0;
    out_if.ready = 1'b0;
    reg_k5 = 1'b0;
    reg_w = 11'd1024;
    reg_h = 11'd1024;
    reg_coef[0] = '0;
    reg_coef[1] = '0;
    reg_coef[2] = 60'd256;
    reg_coef[3] = '0;
    reg_coef[4] = '0;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    frame_open = 0; input_complete = 0;
    frame_w = 1; frame_h = 1; frame_off = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Identity 3x3 kernel on a 3x3 frame, with a drain while idle, a drain before the
    // input is complete and a pixel after it.
    write_reg(REG_KSIZE, 60'd0);
    write_reg(REG_WIDTH, 60'd3);
    write_reg(REG_HEIGHT, 60'd3);
    write_reg(REG_COEF_A, 60'd0);
    write_reg(REG_COEF_B, 60'd256 << 12);
    write_reg(REG_COEF_C, 60'd0);
    write_reg(REG_COEF_D, 60'd0);
    write_reg(REG_COEF_E, 60'd0);
    push_word(OP_DRAIN, 8'd0);
    push_word(OP_PIXEL, 8'd0);
    push_word(OP_DRAIN, 8'd255);
    for (int i = 1; i < 9; i++) push_word(OP_PIXEL, (i % 2) ? 8'd255 : 8'd0);
    push_word(OP_PIXEL, 8'd255);
    for (int i = 0; i < 3; i++) push_word(OP_DRAIN, 8'd0);
    wait_idle();

    // Extreme coefficients with the 5x5 kernel on a short 2x1 frame, then a single pixel frame.
    write_reg(REG_KSIZE, 60'd1);
    write_reg(REG_WIDTH, 60'd2);
    write_reg(REG_HEIGHT, 60'd1);
    write_reg(REG_COEF_A, {5{12'h7FF}});
    write_reg(REG_COEF_E, {5{12'h800}});
    void'(queue_frame(1, 0));
    wait_idle();
    write_reg(REG_WIDTH, 60'd1);
    void'(queue_frame(2, 0));
    wait_idle();

    // Largest sizes.
    write_reg(REG_WIDTH, 60'd1024);
    write_reg(REG_HEIGHT, 60'd1);
    void'(queue_frame(0, 0));
    wait_idle();
    write_reg(REG_KSIZE, 60'd0);
    write_reg(REG_WIDTH, 60'd1);
    write_reg(REG_HEIGHT, 60'd1024);
    void'(queue_frame(0, 1));
    wait_idle();

    while (random_words < 550) begin
      if ($urandom_range(0, 1)) write_reg(REG_KSIZE, $urandom_range(0, 1));
      write_reg(REG_WIDTH, ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                         : $urandom_range(1, 12));
      write_reg(REG_HEIGHT, $urandom_range(1, 6));
      for (int r = 0; r < KMAX; r++)
        if ($urandom_range(0, 1)) write_reg(reg_idx_t'(REG_COEF_A + r), random_coef_row());
      if (!hold_go && random_words > 200) begin
        write_reg(REG_WIDTH, 60'd12);
        write_reg(REG_HEIGHT, 60'd6);
        @(posedge clk);
        hold_go <= 1'b1;
      end
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++)
        random_words += queue_frame(($urandom_range(0, 5) == 0) ? 2 : 0,
                                    $urandom_range(0, 2) != 0);
      wait_idle();
    end

    if (errors == 0 && expected_results.size() == 0) begin
      $display("image_kernel_convolution_core test passed");
    end else begin
      $display("image_kernel_convolution_core test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("image_kernel_convolution_core test failed");
    $finish;
  end

endmodule

/* image_kernel_convolution_core.f */
sv/ikc_pkg.sv
sv/ikc_in_if.sv
sv/ikc_out_if.sv
sv/ikc_cfg_if.sv
sv/ikc_line_mem.sv
sv/ikc_mac.sv
sv/ikc_out_fifo.sv
sv/image_kernel_convolution_core.sv
tb/tb.sv
